FILE: rtl/core/pic_pkg.sv
// ----------------------------------------------------------------------------
// pic_pkg
// shared codes, register offsets and stream widths of the interrupt controller
// ----------------------------------------------------------------------------
package pic_pkg;

  localparam int unsigned NumBanksDefault = 1;
  localparam int unsigned LinesPerBank    = 32;
  localparam int unsigned PrioW           = 5;
  localparam int unsigned VecW            = 7;

  localparam int unsigned SDataW = 56;
  localparam int unsigned SUserW = 2;
  localparam int unsigned MDataW = 40;
  localparam int unsigned MUserW = 1;

  typedef enum logic [1:0] {
    KindLine  = 2'd0,
    KindRead  = 2'd1,
    KindWrite = 2'd2,
    KindNone  = 2'd3
  } kind_e;

  localparam logic [7:0] OffPending  = 8'h00;
  localparam logic [7:0] OffMask     = 8'h04;
  localparam logic [7:0] OffIrqVec   = 8'h10;
  localparam logic [7:0] OffFiqVec   = 8'h14;
  localparam logic [7:0] OffControl  = 8'h18;
  localparam logic [7:0] OffCfgFirst = 8'h1c;
  localparam logic [7:0] OffCfgLast  = 8'h98;
  localparam logic [7:0] OffSwSet    = 8'h9c;

  localparam int unsigned OutIrq = 0;
  localparam int unsigned OutFiq = 1;

endpackage

FILE: rtl/core/priority_interrupt_controller_top.sv
// ----------------------------------------------------------------------------
// priority_interrupt_controller_top
// vectored irq/fiq interrupt controller, 32 lines per bank, line priorities
// held in a synchronous memory and scanned one line per cycle
// ----------------------------------------------------------------------------
// channel   dir  tdata                                          tuser
// s_axis    in   line_index, line_level, address, write_data    kind
// m_axis    out  read_data, irq_level, fiq_level                bad_access
//
// an item without output evaluation goes from transfer through the exec and check
// states to the response state; an item that evaluates an armed output with work
// to do also scans the priority memory over every line and then the fin state
// input is taken only between items; a result waiting on m_axis does not
// block the next input transfer, only the next result
// reset clears all line state, masks all lines and arms both outputs
// ----------------------------------------------------------------------------
module priority_interrupt_controller_top
  import pic_pkg::*;
#(
  parameter int unsigned NUM_BANKS = NumBanksDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // line_index[6:0], line_level[7], address[17:8], write_data[49:18], zero pad
  input  logic [SDataW-1:0] s_axis_tdata,
  // kind[1:0]
  input  logic [SUserW-1:0] s_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // read_data[31:0], irq_level[32], fiq_level[33], zero pad
  output logic [MDataW-1:0] m_axis_tdata,
  // bad_access[0]
  output logic [MUserW-1:0] m_axis_tuser
);

  localparam int unsigned NumLines = NUM_BANKS * LinesPerBank;
  localparam int unsigned LineW    = $clog2(NumLines);
  localparam logic [LineW-1:0] LastLine = LineW'(NumLines - 1);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StExec  = 3'd1;
  localparam logic [2:0] StCheck = 3'd2;
  localparam logic [2:0] StScan  = 3'd3;
  localparam logic [2:0] StFin   = 3'd4;
  localparam logic [2:0] StResp  = 3'd5;

  logic [2:0] state_q, state_d;

  // captured item
  kind_e       kind_q;
  logic [6:0]  line_q;
  logic        line_lvl_q;
  logic [9:0]  addr_q;
  logic [31:0] data_q;
  logic [LineW-1:0] cfg_addr_q;

  // line state
  logic [NumLines-1:0] pend_q, pend_d;
  logic [NumLines-1:0] high_q, high_d;
  logic [NumLines-1:0] mask_q, mask_d;
  logic [NumLines-1:0] route_q, route_d;
  logic [NumLines-1:0] sense_q, sense_d;
  logic [NumLines-1:0] prio_vld_q, prio_vld_d;

  // output state, index 0 irq and 1 fiq
  logic [1:0] armed_q, armed_d;
  logic [1:0] outlvl_q, outlvl_d;
  logic [1:0] req_q, req_d;
  logic [1:0] scan_q, scan_d;
  logic [VecW-1:0] vec_q [2];

  // scan trackers
  logic [1:0]       found_q, found_d;
  logic [PrioW-1:0] best_q [2];
  logic [PrioW-1:0] best_d [2];
  logic [LineW-1:0] win_q [2];
  logic [LineW-1:0] win_d [2];
  logic [LineW-1:0] cnt_q, cnt_d;
  logic [LineW-1:0] pidx_q;
  logic             pv_q, pv_d;

  // result
  logic [31:0] rd_q, rd_d;
  logic        bad_q, bad_d;
  logic              m_valid_q;
  logic [MDataW-1:0] m_data_q;
  logic [MUserW-1:0] m_user_q;

  // priority memory
  logic [PrioW-1:0] prio_mem [NumLines];
  logic [PrioW-1:0] prio_rd_q;
  logic             rvld_q;
  logic [PrioW-1:0] prio_eff;
  logic [LineW-1:0] mem_raddr;
  logic             mem_we;
  logic [PrioW-1:0] mem_wdata;

  logic             s_xfer;
  logic [9:0]       addr_in;
  logic [7:0]       cfg_off_in;
  logic [6:0]       cfg_lin_in;

  logic [NumLines-1:0] routed [2];
  logic [1:0]          go;

  logic [1:0]  bank;
  logic [7:0]  off;
  logic        bank_ok;
  logic        is_cfg;
  logic [31:0] bank_pend, bank_mask, bank_high, bank_sense;
  logic [31:0] low_bit;
  logic [4:0]  low_idx;
  logic [6:0]  sw_lin;
  logic        ev_en, ev_lvl;
  logic [LineW-1:0] ev_idx;
  logic [VecW-1:0]  rvec;
  logic [LineW-1:0] cfg_bit;

  assign s_axis_tready = (state_q == StIdle);
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  assign addr_in    = s_axis_tdata[17:8];
  assign cfg_off_in = addr_in[7:0] - OffCfgFirst;
  assign cfg_lin_in = {addr_in[9:8], cfg_off_in[6:2]};
  assign mem_raddr  = (state_q == StIdle) ? cfg_lin_in[LineW-1:0] : cnt_q;
  assign prio_eff   = rvld_q ? prio_rd_q : '0;

  assign routed[OutIrq] = pend_q & ~mask_q & ~route_q;
  assign routed[OutFiq] = pend_q & ~mask_q & route_q;

  assign bank    = addr_q[9:8];
  assign off     = addr_q[7:0];
  assign bank_ok = 32'(bank) < NUM_BANKS;
  assign is_cfg  = (off >= OffCfgFirst) && (off <= OffCfgLast) && (off[1:0] == 2'b00);
  assign cfg_bit = cfg_addr_q;
  assign low_bit = data_q & (~data_q + 32'd1);
  assign sw_lin  = {bank, low_idx};

  always_comb begin
    low_idx = '0;
    for (int i = 0; i < 32; i++) begin
      if (low_bit[i]) begin
        low_idx = low_idx | 5'(i);
      end
    end
  end

  always_comb begin
    bank_pend  = '0;
    bank_mask  = '0;
    bank_high  = '0;
    bank_sense = '0;
    for (int b = 0; b < NUM_BANKS; b++) begin
      if (32'(bank) == b) begin
        bank_pend  = pend_q[b*32 +: 32];
        bank_mask  = mask_q[b*32 +: 32];
        bank_high  = high_q[b*32 +: 32];
        bank_sense = sense_q[b*32 +: 32];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      go[k] = req_q[k] && armed_q[k] && (|routed[k]);
    end
  end

  // item execution and output evaluation
  always_comb begin
    pend_d     = pend_q;
    high_d     = high_q;
    mask_d     = mask_q;
    route_d    = route_q;
    sense_d    = sense_q;
    prio_vld_d = prio_vld_q;
    armed_d    = armed_q;
    outlvl_d   = outlvl_q;
    req_d      = req_q;
    scan_d     = scan_q;
    rd_d       = rd_q;
    bad_d      = bad_q;
    mem_we     = 1'b0;
    mem_wdata  = data_q[6:2];
    ev_en      = 1'b0;
    ev_lvl     = 1'b1;
    ev_idx     = line_q[LineW-1:0];
    rvec       = '0;

    if (state_q == StExec) begin
      req_d = '0;
      rd_d  = '0;
      bad_d = 1'b0;
      unique case (kind_q)
        KindLine: begin
          ev_en  = 32'(line_q) < NumLines;
          ev_lvl = line_lvl_q;
        end
        KindRead: begin
          if (!bank_ok) begin
            bad_d = 1'b1;
          end else if (off == OffPending) begin
            rd_d = bank_pend;
          end else if (off == OffMask) begin
            rd_d = bank_mask;
          end else if ((off == OffIrqVec || off == OffFiqVec) && bank == 2'd0) begin
            rvec = (off == OffIrqVec) ? vec_q[OutIrq] : vec_q[OutFiq];
            rd_d = 32'(rvec);
            if (32'(rvec) < NumLines && !sense_q[rvec[LineW-1:0]]) begin
              pend_d[rvec[LineW-1:0]] = 1'b0;
            end
          end else if (off == OffControl && bank == 2'd0) begin
            rd_d = '0;
          end else if (is_cfg) begin
            rd_d = {25'd0, prio_eff, sense_q[cfg_bit], route_q[cfg_bit]};
          end else if (off == OffSwSet) begin
            rd_d = '0;
          end else begin
            bad_d = 1'b1;
          end
        end
        KindWrite: begin
          if (!bank_ok) begin
            bad_d = 1'b1;
          end else if (off == OffPending) begin
            for (int b = 0; b < NUM_BANKS; b++) begin
              if (32'(bank) == b) begin
                pend_d[b*32 +: 32] = bank_pend & (data_q | (bank_high & bank_sense));
              end
            end
          end else if (off == OffMask) begin
            for (int b = 0; b < NUM_BANKS; b++) begin
              if (32'(bank) == b) begin
                mask_d[b*32 +: 32] = data_q;
              end
            end
            req_d = 2'b11;
          end else if (off == OffControl && bank == 2'd0) begin
            if (data_q[1]) begin
              outlvl_d[OutFiq] = 1'b0;
              armed_d[OutFiq]  = 1'b1;
              req_d[OutFiq]    = 1'b1;
            end
            if (data_q[0]) begin
              outlvl_d[OutIrq] = 1'b0;
              armed_d[OutIrq]  = 1'b1;
              req_d[OutIrq]    = 1'b1;
            end
          end else if (is_cfg) begin
            mem_we              = 1'b1;
            prio_vld_d[cfg_bit] = 1'b1;
            sense_d[cfg_bit]    = data_q[1];
            route_d[cfg_bit]    = data_q[0];
          end else if (off == OffSwSet) begin
            ev_en  = (data_q != '0);
            ev_idx = sw_lin[LineW-1:0];
          end else begin
            bad_d = 1'b1;
          end
        end
        default: ;
      endcase

      if (ev_en) begin
        if (ev_lvl) begin
          if (!pend_q[ev_idx] && (sense_q[ev_idx] || !high_q[ev_idx])) begin
            pend_d[ev_idx] = 1'b1;
            req_d          = 2'b11;
          end
          high_d[ev_idx] = 1'b1;
        end else begin
          if (sense_q[ev_idx]) begin
            pend_d[ev_idx] = 1'b0;
          end
          high_d[ev_idx] = 1'b0;
        end
      end
    end

    if (state_q == StCheck) begin
      scan_d  = go;
      armed_d = armed_q & ~go;
    end

    if (state_q == StFin) begin
      outlvl_d = outlvl_q | scan_q;
    end
  end

  // running minimum, ties to the later line
  always_comb begin
    found_d = found_q;
    for (int k = 0; k < 2; k++) begin
      best_d[k] = best_q[k];
      win_d[k]  = win_q[k];
      if (state_q == StCheck) begin
        found_d[k] = 1'b0;
      end else if (pv_q && scan_q[k] && routed[k][pidx_q] &&
                   (!found_q[k] || prio_eff <= best_q[k])) begin
        found_d[k] = 1'b1;
        best_d[k]  = prio_eff;
        win_d[k]   = pidx_q;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    pv_d    = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (s_xfer) begin
          state_d = StExec;
        end
      end
      StExec: begin
        state_d = StCheck;
      end
      StCheck: begin
        cnt_d   = '0;
        state_d = (go != 2'b00) ? StScan : StResp;
      end
      StScan: begin
        pv_d  = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastLine) begin
          state_d = StFin;
        end
      end
      StFin: begin
        state_d = StResp;
      end
      StResp: begin
        if (!m_valid_q || m_axis_tready) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      pend_q     <= '0;
      high_q     <= '0;
      mask_q     <= '1;
      route_q    <= '0;
      sense_q    <= '0;
      prio_vld_q <= '0;
      armed_q    <= 2'b11;
      outlvl_q   <= '0;
      req_q      <= '0;
      scan_q     <= '0;
      vec_q[0]   <= '0;
      vec_q[1]   <= '0;
      pv_q       <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      pend_q     <= pend_d;
      high_q     <= high_d;
      mask_q     <= mask_d;
      route_q    <= route_d;
      sense_q    <= sense_d;
      prio_vld_q <= prio_vld_d;
      armed_q    <= armed_d;
      outlvl_q   <= outlvl_d;
      req_q      <= req_d;
      scan_q     <= scan_d;
      pv_q       <= pv_d;
      if (state_q == StFin) begin
        for (int k = 0; k < 2; k++) begin
          if (scan_q[k]) begin
            vec_q[k] <= VecW'(win_d[k]);
          end
        end
      end
      if (state_q == StResp && (!m_valid_q || m_axis_tready)) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      kind_q     <= kind_e'(s_axis_tuser[1:0]);
      line_q     <= s_axis_tdata[6:0];
      line_lvl_q <= s_axis_tdata[7];
      addr_q     <= addr_in;
      data_q     <= s_axis_tdata[49:18];
      cfg_addr_q <= cfg_lin_in[LineW-1:0];
    end
    rd_q    <= rd_d;
    bad_q   <= bad_d;
    cnt_q   <= cnt_d;
    pidx_q  <= cnt_q;
    found_q <= found_d;
    for (int k = 0; k < 2; k++) begin
      best_q[k] <= best_d[k];
      win_q[k]  <= win_d[k];
    end
    if (state_q == StResp && (!m_valid_q || m_axis_tready)) begin
      m_data_q <= {6'd0, outlvl_q[OutFiq], outlvl_q[OutIrq], rd_q};
      m_user_q <= bad_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      prio_mem[cfg_addr_q] <= mem_wdata;
    end
    prio_rd_q <= prio_mem[mem_raddr];
    rvld_q    <= prio_vld_q[mem_raddr];
  end

endmodule
